// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the asserting RTL file, grouped_radix_digit_emitter.sv.
// Each check samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/gre_pkg.sv =====
`default_nettype none
package gre_pkg;

	// Default width of the input value
	localparam int GRE_VALUE_BITS = 64;

	// Configuration field widths
	localparam int RADIX_W = 6;
	localparam int GROUP_W = 7;
	localparam int SEP_W   = 21;
	localparam int CHAR_W  = 7;
	localparam int DIGIT_W = 6;

	// Configuration register indexes
	localparam logic [2:0] REG_RADIX = 3'd0;
	localparam logic [2:0] REG_UPPER = 3'd1;
	localparam logic [2:0] REG_GROUP = 3'd2;
	localparam logic [2:0] REG_SEP   = 3'd3;

	// Character codes and digit limits
	localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'd97;
	localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'd65;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE   = 6'd9;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 6'd10;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture value and configuration, clear counters
		logic div_en;   // run one byte step of the divide
		logic emit_rd;  // read the next digit, most significant first
	} gre_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic chunk_last; // this byte step finishes a digit
		logic quot_zero;  // quotient after this digit is zero
		logic k_zero;     // read index points at the final digit
	} gre_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/grouped_radix_digit_emitter.sv =====
`default_nettype none
// Prints the magnitude of one signed value as digits in a base from 2 to 36,
// most significant digit first, one result beat per digit.
// Input: pulse start with value while busy is low; the value is taken at that
// edge and busy rises on the next cycle.
// Output: each digit is on digit_char, separator_after, separator_code and last
// for exactly one cycle, marked by strobe. Beats of one number come in
// consecutive cycles; last marks the final digit. The receiver cannot stall.
// Configuration: cfg_wr with cfg_addr and cfg_wdata writes radix (0),
// upper_case (1), group_size (2) or separator_char (3); other addresses are
// ignored. Writes take effect at the next accepted value.
// Sequence: the value is split into C = ceil(VALUE_BITS/8) byte chunks, and
// the divide loop runs one byte of restoring division per cycle over every
// chunk for each of the D digits; then the digit memory is read back at one
// digit per cycle, each read registered before it drives a beat. Another
// value may be taken while the last beat is on the outputs.
// Reset: arst_n returns the controller to idle and the registers to base 10,
// lower case, groups of 3 and separator 44; no beat is pending after reset.
`include "assert_macros.svh"
module grouped_radix_digit_emitter import gre_pkg::*; #(
	parameter int VALUE_BITS = GRE_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         cfg_wr,
	input  logic [2:0]                   cfg_addr,
	input  logic [SEP_W-1:0]             cfg_wdata,
	output logic                         strobe,
	output logic [CHAR_W-1:0]            digit_char,
	output logic                         separator_after,
	output logic [SEP_W-1:0]             separator_code,
	output logic                         last
);

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [GROUP_W-1:0] GROUP_MIN = 7'd2;

	logic [RADIX_W-1:0] radix_q;
	logic               upper_q;
	logic [GROUP_W-1:0] group_q;
	logic [SEP_W-1:0]   sep_q;

	logic [RADIX_W-1:0] radix_eff;
	logic [GROUP_W-1:0] group_eff;

	gre_cmd_t  cmd;
	gre_stat_t stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= 6'd10;
			upper_q <= 1'b0;
			group_q <= 7'd3;
			sep_q   <= 21'd44;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_RADIX: radix_q <= cfg_wdata[RADIX_W-1:0];
				REG_UPPER: upper_q <= cfg_wdata[0];
				REG_GROUP: group_q <= cfg_wdata[GROUP_W-1:0];
				REG_SEP:   sep_q   <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Clamp base and group size into their working ranges
	assign radix_eff = (radix_q < RADIX_MIN) ? RADIX_MIN :
		(radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;
	assign group_eff = (group_q < GROUP_MIN) ? GROUP_MIN : group_q;

	gre_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	gre_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.value           (value),
		.radix           (radix_eff),
		.upper_case      (upper_q),
		.group_size      (group_eff),
		.separator_char  (sep_q),
		.strobe          (strobe),
		.digit_char      (digit_char),
		.separator_after (separator_after),
		.separator_code  (separator_code),
		.last            (last)
	);

	`ASSERT_CLK(a_start_busy, (start && !busy) |=> busy, "accepted value did not raise busy")
	`ASSERT_CLK(a_beat_after_busy, strobe |-> $past(busy), "beat without a busy cycle before it")
	`ASSERT_CLK(a_beats_contiguous, (strobe && !last) |=> strobe, "gap inside one number's beats")
	`ASSERT_NEVER(a_last_no_sep, strobe && last && separator_after, "separator after final digit")

endmodule
`default_nettype wire

// ===== hw/rtl/gre_ctrl.sv =====
`default_nettype none
module gre_ctrl import gre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  gre_stat_t stat,
	output gre_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Advance through divide and emit phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (stat.chunk_last && stat.quot_zero) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.k_zero) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Decode commands from state
	assign busy        = (state_q != ST_IDLE);
	assign cmd.load    = start && (state_q == ST_IDLE);
	assign cmd.div_en  = (state_q == ST_DIVIDE);
	assign cmd.emit_rd = (state_q == ST_EMIT);

endmodule
`default_nettype wire

// ===== hw/rtl/gre_datapath.sv =====
`default_nettype none
module gre_datapath import gre_pkg::*; #(
	parameter int VALUE_BITS = GRE_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gre_cmd_t              cmd,
	output gre_stat_t             stat,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	input  logic                  upper_case,
	input  logic [GROUP_W-1:0]    group_size,
	input  logic [SEP_W-1:0]      separator_char,
	output logic                  strobe,
	output logic [CHAR_W-1:0]     digit_char,
	output logic                  separator_after,
	output logic [SEP_W-1:0]      separator_code,
	output logic                  last
);

	localparam int CHUNKS = (VALUE_BITS + 7) / 8;
	localparam int W      = CHUNKS * 8;
	localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int IDX_W  = $clog2(VALUE_BITS);

	// One byte of restoring division by a narrow divisor
	function automatic logic [8+DIGIT_W-1:0] div_byte(
		input logic [DIGIT_W-1:0] rem_in,
		input logic [7:0]         dbyte,
		input logic [RADIX_W-1:0] base
	);
		logic [DIGIT_W:0]   rr;
		logic [DIGIT_W-1:0] rem;
		logic [7:0]         q;
		rem = rem_in;
		q   = '0;
		for (int i = 7; i >= 0; i--) begin
			rr = {rem, dbyte[i]};
			if (rr >= {1'b0, base}) begin
				q[i] = 1'b1;
				rr   = rr - {1'b0, base};
			end
			rem = rr[DIGIT_W-1:0];
		end
		return {q, rem};
	endfunction

	logic [W-1:0]         w_q;
	logic [DIGIT_W-1:0]   r_q;
	logic [CH_W-1:0]      chunk_q;
	logic [IDX_W-1:0]     count_q;
	logic [IDX_W-1:0]     k_q;
	logic [GROUP_W-1:0]   mod_q;
	logic [GROUP_W-1:0]   kmod_q;
	logic [RADIX_W-1:0]   base_q;
	logic [GROUP_W-1:0]   group_q;
	logic                 upper_q;
	logic [SEP_W-1:0]     sep_q;
	logic [DIGIT_W-1:0]   mem [VALUE_BITS];

	logic [VALUE_BITS-1:0] mag;
	logic [8+DIGIT_W-1:0]  step;
	logic [7:0]            q_byte;
	logic [DIGIT_W-1:0]    r_next;
	logic [W+7:0]          w_cat;
	logic [W-1:0]          w_next;
	logic [GROUP_W-1:0]    mod_inc;

	logic                  strobe_s1;
	logic                  last_s1;
	logic                  sep_s1;
	logic [DIGIT_W-1:0]    digit_s1;

	// Magnitude of the signed input
	assign mag = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

	// Byte step of the divide on the top byte of the rotating word
	assign step   = div_byte(r_q, w_q[W-1 -: 8], base_q);
	assign q_byte = step[8+DIGIT_W-1 -: 8];
	assign r_next = step[DIGIT_W-1:0];
	assign w_cat  = {w_q, q_byte};
	assign w_next = w_cat[W-1:0];
	assign mod_inc = mod_q + GROUP_W'(1);

	assign stat.chunk_last = (chunk_q == CH_W'(CHUNKS - 1));
	assign stat.quot_zero  = (w_next == '0);
	assign stat.k_zero     = (k_q == '0);

	// Hold operands and run divide and read-out counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			count_q <= '0;
			k_q     <= '0;
			mod_q   <= '0;
			kmod_q  <= '0;
		end else if (cmd.load) begin
			chunk_q <= '0;
			count_q <= '0;
			mod_q   <= '0;
		end else if (cmd.div_en) begin
			if (stat.chunk_last) begin
				chunk_q <= '0;
				count_q <= count_q + IDX_W'(1);
				k_q     <= count_q;
				kmod_q  <= mod_q;
				mod_q   <= (mod_inc == group_q) ? '0 : mod_inc;
			end else begin
				chunk_q <= chunk_q + CH_W'(1);
			end
		end else if (cmd.emit_rd) begin
			k_q    <= k_q - IDX_W'(1);
			kmod_q <= (kmod_q == '0) ? (group_q - GROUP_W'(1)) : (kmod_q - GROUP_W'(1));
		end
	end

	// Capture operands and advance the dividend word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q     <= W'(mag);
			r_q     <= '0;
			base_q  <= radix;
			group_q <= group_size;
			upper_q <= upper_case;
			sep_q   <= separator_char;
		end else if (cmd.div_en) begin
			w_q <= w_next;
			r_q <= stat.chunk_last ? '0 : r_next;
		end
	end

	// Store each finished digit, least significant first
	always_ff @(posedge clk) begin
		if (cmd.div_en && stat.chunk_last) mem[count_q] <= r_next;
	end

	// Read digits back most significant first
	always_ff @(posedge clk) begin
		if (cmd.emit_rd) begin
			digit_s1 <= mem[k_q];
			last_s1  <= (k_q == '0);
			sep_s1   <= (k_q != '0) && (kmod_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_s1 <= 1'b0;
		else         strobe_s1 <= cmd.emit_rd;
	end

	// Map the digit to its character and drive the result beat
	always_comb begin
		if (digit_s1 <= DIGIT_NINE) begin
			digit_char = CHAR_ZERO + CHAR_W'(digit_s1);
		end else begin
			digit_char = (upper_q ? CHAR_UPPER_A : CHAR_LOWER_A)
				+ CHAR_W'(digit_s1 - DIGIT_TEN);
		end
	end

	assign strobe          = strobe_s1;
	assign separator_after = sep_s1;
	assign separator_code  = sep_s1 ? sep_q : '0;
	assign last            = last_s1;

endmodule
`default_nettype wire
